>>> rtl/z_array_pattern_matcher_core_assert.svh
// ----------------------------------------------------------------------------
// Pattern matcher assertion macros
// Concurrent checks on clk / rst_n; they compile to nothing under SYNTHESIS.
// ----------------------------------------------------------------------------
`ifndef Z_ARRAY_PATTERN_MATCHER_CORE_ASSERT_SVH
`define Z_ARRAY_PATTERN_MATCHER_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define ZAPM_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("zapm: assertion failed");

// next-cycle implication
`define ZAPM_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("zapm: assertion failed");

`else

`define ZAPM_ASSERT_IMP(lbl, ante, cons)
`define ZAPM_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

>>> rtl/zapm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zapm_pkg
// Shared constants, codes and types of the pattern matcher.
// ----------------------------------------------------------------------------
package zapm_pkg;

    // default sizing
    localparam int PATTERN_MAX_DEF = 64;
    localparam int TEXT_MAX_DEF    = 65536;

    // field widths
    localparam int SYM_W  = 8;
    localparam int IDX_W  = 6;
    localparam int LEN_W  = 7;
    localparam int POS_W  = 16;
    localparam int CNT_W  = 17;
    localparam int TPOS_W = 17;

    // saturation limits
    localparam int POS_REG_MAX = 131071;
    localparam int POS_SAT     = 65535;
    localparam int COUNT_SAT   = 65536;

    // queue depths
    localparam int JQ_DEPTH = 4;
    localparam int OQ_DEPTH = 2;

    // request opcodes
    localparam logic OP_PATTERN = 1'b0;
    localparam logic OP_TEXT    = 1'b1;

    // result kinds
    localparam logic KIND_MATCH   = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // classified text byte, front to back
    typedef struct packed {
        logic             hit;
        logic             eot;
        logic [POS_W-1:0] start;
    } job_t;

    // one result
    typedef struct packed {
        logic             kind;
        logic [POS_W-1:0] match_position;
        logic [CNT_W-1:0] match_count;
        logic             found;
        logic             last_of_run;
    } result_t;

    typedef enum logic [0:0] {
        BK_RUN,
        BK_SUMMARY
    } bk_state_t;

endpackage

>>> rtl/zapm_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zapm_fifo
// Small register-based FIFO with occupancy count.
// ----------------------------------------------------------------------------
module zapm_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  logic [WIDTH-1:0]           wdata,
    input  logic                       pop,
    output logic [WIDTH-1:0]           rdata,
    output logic                       empty,
    output logic                       full,
    output logic [$clog2(DEPTH+1)-1:0] count
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             push_ok;
    logic             pop_ok;

    assign empty   = (count_reg == '0);
    assign full    = (count_reg == CNT_W'(DEPTH));
    assign count   = count_reg;
    assign rdata   = mem_reg[rd_ptr_reg];
    assign push_ok = push && !full;
    assign pop_ok  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push_ok)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop_ok)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push_ok && !pop_ok)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop_ok && !push_ok)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

>>> rtl/zapm_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zapm_front
// Takes requests: pattern writes, text window shift, position tracking and
// the full-window compare. Emits one classified job per text byte.
// ----------------------------------------------------------------------------
module zapm_front #(
    parameter int PATTERN_MAX = zapm_pkg::PATTERN_MAX_DEF,
    parameter int TEXT_MAX    = zapm_pkg::TEXT_MAX_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       accept,
    input  logic                       op,
    input  logic [zapm_pkg::IDX_W-1:0] pattern_index,
    input  logic [zapm_pkg::SYM_W-1:0] symbol,
    input  logic                       end_of_text,
    input  logic                       cfg_we,
    input  logic [zapm_pkg::LEN_W-1:0] cfg_wdata,
    output logic                       job_push,
    output zapm_pkg::job_t             job
);

    localparam int PIDX_W  = $clog2(PATTERN_MAX);
    localparam int MLEN_W  = $clog2(PATTERN_MAX + 1);
    localparam int SHIFT_W = MLEN_W + 3;
    localparam int VEC_W   = PATTERN_MAX * zapm_pkg::SYM_W;
    localparam int POS_CAP = (TEXT_MAX > zapm_pkg::POS_REG_MAX) ?
                             zapm_pkg::POS_REG_MAX : TEXT_MAX;
    localparam int TP_W    = zapm_pkg::TPOS_W;

    logic [zapm_pkg::LEN_W-1:0] len_reg;
    logic [zapm_pkg::SYM_W-1:0] pat_reg [PATTERN_MAX];
    logic [zapm_pkg::SYM_W-1:0] win_reg [PATTERN_MAX];
    logic [VEC_W-1:0]           apat_reg;
    logic [VEC_W-1:0]           apat_next;
    logic [PATTERN_MAX-1:0]     mask_reg;
    logic [PATTERN_MAX-1:0]     mask_next;
    logic [TP_W-1:0]            tpos_reg;
    logic [TP_W-1:0]            tpos_next;
    logic                       job_valid_reg;
    logic                       job_ok_reg;
    logic                       job_ok_next;
    logic                       job_eot_reg;
    logic [zapm_pkg::POS_W-1:0] job_start_reg;
    logic [zapm_pkg::POS_W-1:0] job_start_next;

    logic [MLEN_W-1:0]          m_eff;
    logic [VEC_W-1:0]           pat_rev;
    logic [MLEN_W-1:0]          shift_ent;
    logic [TP_W:0]              p_plus1;
    logic [TP_W:0]              start_full;
    logic [PATTERN_MAX-1:0]     eqv;
    logic                       text_acc;
    logic                       pat_acc;

    assign text_acc = accept && (op == zapm_pkg::OP_TEXT);
    assign pat_acc  = accept && (op == zapm_pkg::OP_PATTERN)
                      && (32'(pattern_index) < PATTERN_MAX);

    // effective length, capped at the store depth
    always_comb
    begin
        if (32'(len_reg) > PATTERN_MAX)
        begin
            m_eff = MLEN_W'(PATTERN_MAX);
        end
        else
        begin
            m_eff = MLEN_W'(len_reg);
        end
    end

    // Align the pattern to window ages: entry j of apat holds pattern[m-1-j].
    // Reversing the store and shifting down by PATTERN_MAX-m gives exactly that.
    always_comb
    begin
        for (int i = 0; i < PATTERN_MAX; i++)
        begin
            pat_rev[i*zapm_pkg::SYM_W +: zapm_pkg::SYM_W] = pat_reg[PATTERN_MAX-1-i];
            mask_next[i] = (MLEN_W'(i) < m_eff);
        end
    end

    assign shift_ent = MLEN_W'(PATTERN_MAX) - m_eff;
    assign apat_next = pat_rev >> SHIFT_W'({shift_ent, 3'b000});

    // start of the candidate window ending at this byte
    assign p_plus1     = {1'b0, tpos_reg} + (TP_W+1)'(1);
    assign job_ok_next = (m_eff != '0) && (p_plus1 >= (TP_W+1)'(m_eff));
    assign start_full  = p_plus1 - (TP_W+1)'(m_eff);
    assign job_start_next = (start_full > (TP_W+1)'(zapm_pkg::POS_SAT)) ?
                            zapm_pkg::POS_W'(zapm_pkg::POS_SAT) :
                            start_full[zapm_pkg::POS_W-1:0];

    always_comb
    begin
        tpos_next = tpos_reg;
        if (end_of_text)
        begin
            tpos_next = '0;
        end
        else if (32'(tpos_reg) < POS_CAP)
        begin
            tpos_next = tpos_reg + TP_W'(1);
        end
    end

    // compare stage: window and aligned pattern, one byte lane per age
    always_comb
    begin
        for (int j = 0; j < PATTERN_MAX; j++)
        begin
            eqv[j] = (win_reg[j] == apat_reg[j*zapm_pkg::SYM_W +: zapm_pkg::SYM_W])
                     || !mask_reg[j];
        end
    end

    assign job_push  = job_valid_reg;
    assign job.hit   = job_ok_reg && (&eqv);
    assign job.eot   = job_eot_reg;
    assign job.start = job_start_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg       <= zapm_pkg::LEN_W'(1);
            tpos_reg      <= '0;
            job_valid_reg <= 1'b0;
            mask_reg      <= '0;
        end
        else
        begin
            mask_reg      <= mask_next;
            job_valid_reg <= text_acc;
            if (cfg_we)
            begin
                len_reg <= cfg_wdata;
            end
            if (text_acc)
            begin
                tpos_reg <= tpos_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        apat_reg <= apat_next;
        if (pat_acc)
        begin
            pat_reg[PIDX_W'(pattern_index)] <= symbol;
        end
        if (text_acc)
        begin
            win_reg[0] <= symbol;
            for (int k = 1; k < PATTERN_MAX; k++)
            begin
                win_reg[k] <= win_reg[k-1];
            end
            job_ok_reg    <= job_ok_next;
            job_eot_reg   <= end_of_text;
            job_start_reg <= job_start_next;
        end
    end

endmodule

>>> rtl/zapm_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zapm_back
// Turns classified jobs into match reports and end-of-text summaries;
// keeps the per-text match count.
// ----------------------------------------------------------------------------
module zapm_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              job_valid,
    input  zapm_pkg::job_t    job,
    output logic              job_pop,
    input  logic              res_full,
    output logic              res_push,
    output zapm_pkg::result_t res
);

    localparam int CW = zapm_pkg::CNT_W;

    zapm_pkg::bk_state_t state_reg;
    zapm_pkg::bk_state_t state_next;
    logic [CW-1:0]       count_reg;
    logic [CW-1:0]       count_next;
    logic [CW-1:0]       count_inc;

    assign count_inc = (count_reg == CW'(zapm_pkg::COUNT_SAT)) ?
                       count_reg : count_reg + CW'(1);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            zapm_pkg::BK_RUN:
            begin
                if (job_valid && job.hit && job.eot && !res_full)
                begin
                    state_next = zapm_pkg::BK_SUMMARY;
                end
            end
            zapm_pkg::BK_SUMMARY:
            begin
                if (!res_full)
                begin
                    state_next = zapm_pkg::BK_RUN;
                end
            end
            default:
            begin
                state_next = zapm_pkg::BK_RUN;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        job_pop            = 1'b0;
        res_push           = 1'b0;
        count_next         = count_reg;
        res.kind           = zapm_pkg::KIND_SUMMARY;
        res.match_position = '0;
        res.match_count    = count_reg;
        res.found          = (count_reg != '0);
        res.last_of_run    = 1'b1;
        case (state_reg)
            zapm_pkg::BK_RUN:
            begin
                if (job_valid)
                begin
                    if (job.hit)
                    begin
                        res.kind           = zapm_pkg::KIND_MATCH;
                        res.match_position = job.start;
                        res.match_count    = count_inc;
                        res.found          = 1'b1;
                        res.last_of_run    = !job.eot;
                        if (!res_full)
                        begin
                            job_pop    = 1'b1;
                            res_push   = 1'b1;
                            count_next = count_inc;
                        end
                    end
                    else if (job.eot)
                    begin
                        if (!res_full)
                        begin
                            job_pop    = 1'b1;
                            res_push   = 1'b1;
                            count_next = '0;
                        end
                    end
                    else
                    begin
                        job_pop = 1'b1;
                    end
                end
            end
            zapm_pkg::BK_SUMMARY:
            begin
                if (!res_full)
                begin
                    res_push   = 1'b1;
                    count_next = '0;
                end
            end
            default:
            begin
                job_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= zapm_pkg::BK_RUN;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

endmodule

>>> rtl/z_array_pattern_matcher_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// z_array_pattern_matcher_core
// Streaming exact byte-pattern matcher with match reports and text summaries.
// ----------------------------------------------------------------------------
// Load the pattern one byte per request (op = pattern, pattern_index, symbol),
// set its length through cfg_we / cfg_wdata while the block is idle, then
// stream text bytes (op = text), one per cycle, marking the last byte of each
// text with end_of_text. Each byte that completes a window equal to the
// pattern yields a match report (kind = match) with the start position and
// the running count; the last byte of a text also yields a summary
// (kind = summary) with the count and found flag, after which position and
// count start over. Pattern writes landing mid-text apply from the next text
// byte on. The '#' separator of the classic pattern#text formulation has no
// special meaning here: matching is plain byte equality. Positions saturate
// at 65535, counts at 65536. Requests are taken one per cycle while full is
// low; the result stage is slower only for a byte that both matches and
// ends the text, because it gives two results. A taken text byte is shifted
// into the window registers, compared against the aligned pattern and
// queued as a job; the result stage then writes its result into the output
// queue, where it sits on the result ports until popped. A four-entry job
// queue sits between the compare front end and the result stage, and a
// two-entry output queue holds results, so either side may stall without
// stopping the other.
// ----------------------------------------------------------------------------
`include "z_array_pattern_matcher_core_assert.svh"

module z_array_pattern_matcher_core #(
    parameter int PATTERN_MAX = zapm_pkg::PATTERN_MAX_DEF,
    parameter int TEXT_MAX    = zapm_pkg::TEXT_MAX_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    // request side
    input  logic                       push,
    output logic                       full,
    input  logic                       op,
    input  logic [zapm_pkg::IDX_W-1:0] pattern_index,
    input  logic [zapm_pkg::SYM_W-1:0] symbol,
    input  logic                       end_of_text,
    // pattern length register
    input  logic                       cfg_we,
    input  logic [zapm_pkg::LEN_W-1:0] cfg_wdata,
    // result side
    output logic                       empty,
    input  logic                       pop,
    output logic                       kind,
    output logic [zapm_pkg::POS_W-1:0] match_position,
    output logic [zapm_pkg::CNT_W-1:0] match_count,
    output logic                       found,
    output logic                       last_of_run
);

    localparam int JQ_CNT_W = $clog2(zapm_pkg::JQ_DEPTH + 1);

    logic              accept;
    logic              jq_push;
    zapm_pkg::job_t    fe_job;
    zapm_pkg::job_t    bk_job;
    logic              jq_pop;
    logic              jq_empty;
    logic              jq_full;
    logic [JQ_CNT_W-1:0] jq_count;
    logic              oq_push;
    logic              oq_full;
    zapm_pkg::result_t bk_res;
    zapm_pkg::result_t oq_res;

    // The front writes into the job queue in the cycle after it takes a text
    // byte, so hold off while that pending job could find the queue full.
    assign full   = (32'(jq_count) + 32'(jq_push)) >= zapm_pkg::JQ_DEPTH;
    assign accept = push && !full;

    zapm_front #(
        .PATTERN_MAX (PATTERN_MAX),
        .TEXT_MAX    (TEXT_MAX)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .op            (op),
        .pattern_index (pattern_index),
        .symbol        (symbol),
        .end_of_text   (end_of_text),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .job_push      (jq_push),
        .job           (fe_job)
    );

    zapm_fifo #(
        .WIDTH ($bits(zapm_pkg::job_t)),
        .DEPTH (zapm_pkg::JQ_DEPTH)
    ) u_job_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (jq_push),
        .wdata (fe_job),
        .pop   (jq_pop),
        .rdata (bk_job),
        .empty (jq_empty),
        .full  (jq_full),
        .count (jq_count)
    );

    zapm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (!jq_empty),
        .job       (bk_job),
        .job_pop   (jq_pop),
        .res_full  (oq_full),
        .res_push  (oq_push),
        .res       (bk_res)
    );

    zapm_fifo #(
        .WIDTH ($bits(zapm_pkg::result_t)),
        .DEPTH (zapm_pkg::OQ_DEPTH)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (oq_push),
        .wdata (bk_res),
        .pop   (pop),
        .rdata (oq_res),
        .empty (empty),
        .full  (oq_full),
        .count ()
    );

    assign kind           = oq_res.kind;
    assign match_position = oq_res.match_position;
    assign match_count    = oq_res.match_count;
    assign found          = oq_res.found;
    assign last_of_run    = oq_res.last_of_run;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    // a pending job must always find room in the job queue
    `ZAPM_ASSERT_IMP(a_jq_no_overflow, jq_push, !jq_full)
    // the result stage never writes into a full output queue
    `ZAPM_ASSERT_IMP(a_oq_no_overflow, oq_push, !oq_full)
    // every text byte taken becomes exactly one job on the next cycle
    `ZAPM_ASSERT_NXT(a_text_makes_job, accept && (op == zapm_pkg::OP_TEXT), jq_push)
    `ZAPM_ASSERT_NXT(a_pattern_no_job, !(accept && (op == zapm_pkg::OP_TEXT)), !jq_push)
    // a summary's found flag agrees with its count
    `ZAPM_ASSERT_IMP(a_summary_found,
        !empty && (kind == zapm_pkg::KIND_SUMMARY), found == (match_count != '0))

endmodule
